### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a plain condition on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, (cond))

`endif

### hw/rtl/tfab_pkg.sv
package tfab_pkg;

    localparam int MAX_FACES  = 4096;
    localparam int INDEX_BITS = 16;

    localparam int VTX_W   = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int ADDR_W  = $clog2(MAX_FACES);
    localparam int CNT_W   = $clog2(MAX_FACES + 1);
    localparam int TET_W   = 16;
    localparam int SLOT_W  = 2;
    localparam int OWNER_W = TET_W + SLOT_W;
    localparam int TRI_W   = 3 * VTX_W;
    localparam int ENTRY_W = TRI_W + OWNER_W;
    localparam int FIDX_W  = 12;

    localparam logic [1:0] FACE_LAST = 2'd3;

    typedef logic [VTX_W-1:0] t_vtx;
    typedef t_vtx [2:0] t_tri;
    typedef t_vtx [3:0] t_tet;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // Faces in order: opposite vertex 3, 2, 1, 0.
    function automatic t_tri face_tri(input t_tet v, input logic [1:0] face);
        t_tri t;
        unique case (face)
            2'd0: t = '{v[2], v[1], v[0]};
            2'd1: t = '{v[3], v[1], v[0]};
            2'd2: t = '{v[3], v[2], v[0]};
            default: t = '{v[3], v[2], v[1]};
        endcase
        return t;
    endfunction

    // True when the two triples hold the same vertices in any of six orders.
    function automatic logic same_face(input t_tri a, input t_tri b);
        logic [2:0][2:0] eq;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                eq[i][j] = (a[i] == b[j]);
            end
        end
        return (eq[0][0] & eq[1][1] & eq[2][2]) |
               (eq[0][0] & eq[1][2] & eq[2][1]) |
               (eq[0][1] & eq[1][0] & eq[2][2]) |
               (eq[0][1] & eq[1][2] & eq[2][0]) |
               (eq[0][2] & eq[1][0] & eq[2][1]) |
               (eq[0][2] & eq[1][1] & eq[2][0]);
    endfunction

endpackage

### hw/rtl/tfab_ram.sv
module tfab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hw/rtl/tet_face_adjacency_builder.sv
// Builds face adjacency for a stream of tetrahedra. Pulse start with four
// vertex indices while busy is low; the block numbers the tetrahedron and
// returns four results, one per face (opposite vertex 3, 2, 1, 0), each on
// the o_ ports for a single cycle marked by o_valid, the fourth with o_last.
// Results cannot be held off. Every face is searched linearly through the
// face table, one entry read per cycle from a single memory, up to a full
// table of 4096 faces. busy stays high from acceptance until the last
// result is issued. The table is not cleared: entries at or above the face
// count are never read.
`include "assert_macros.svh"

module tet_face_adjacency_builder
    import tfab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_vertex_a,
    input  logic [15:0] i_vertex_b,
    input  logic [15:0] i_vertex_c,
    input  logic [15:0] i_vertex_d,
    output logic        o_valid,
    output logic [15:0] o_tet_number,
    output logic [1:0]  o_face_slot,
    output logic [11:0] o_face_index,
    output logic        o_is_new,
    output logic [15:0] o_neighbor_tet,
    output logic [1:0]  o_neighbor_slot,
    output logic        o_table_full,
    output logic        o_last
);

    t_state r_state, n_state;
    t_tet                r_vtx, n_vtx;
    logic [TET_W-1:0]    r_tnum, n_tnum;
    logic [TET_W-1:0]    r_tet_cnt, n_tet_cnt;
    logic [CNT_W-1:0]    r_face_cnt, n_face_cnt;
    logic [1:0]          r_face, n_face;
    logic [CNT_W-1:0]    r_addr, n_addr;
    logic                r_rd_valid, n_rd_valid;
    logic [ADDR_W-1:0]   r_rd_idx, n_rd_idx;

    logic                r_valid, n_valid;
    logic [15:0]         r_o_tnum, n_o_tnum;
    logic [1:0]          r_o_slot, n_o_slot;
    logic [FIDX_W-1:0]   r_o_idx, n_o_idx;
    logic                r_o_new, n_o_new;
    logic [15:0]         r_o_ntet, n_o_ntet;
    logic [1:0]          r_o_nslot, n_o_nslot;
    logic                r_o_full, n_o_full;
    logic                r_o_last, n_o_last;

    logic                rd_en, wr_en;
    logic [ENTRY_W-1:0]  rd_data, wr_data;
    t_tri                cur_tri, rd_tri;
    logic [OWNER_W-1:0]  rd_owner;
    logic [1:0]          cur_slot;
    logic                hit;

    tfab_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_FACES)
    ) u_face_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_face_cnt[ADDR_W-1:0]),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_addr[ADDR_W-1:0]),
        .o_rd_data(rd_data)
    );

    assign cur_tri  = face_tri(r_vtx, r_face);
    assign cur_slot = ~r_face;
    assign rd_tri   = rd_data[TRI_W-1:0];
    assign rd_owner = rd_data[ENTRY_W-1:TRI_W];
    assign wr_data  = {r_tnum, cur_slot, cur_tri};
    assign hit      = r_rd_valid && same_face(cur_tri, rd_tri);

    always_comb begin
        n_state    = r_state;
        n_vtx      = r_vtx;
        n_tnum     = r_tnum;
        n_tet_cnt  = r_tet_cnt;
        n_face_cnt = r_face_cnt;
        n_face     = r_face;
        n_addr     = r_addr;
        n_rd_valid = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_valid    = 1'b0;
        n_o_tnum   = r_o_tnum;
        n_o_slot   = r_o_slot;
        n_o_idx    = r_o_idx;
        n_o_new    = r_o_new;
        n_o_ntet   = r_o_ntet;
        n_o_nslot  = r_o_nslot;
        n_o_full   = r_o_full;
        n_o_last   = r_o_last;
        rd_en      = 1'b0;
        wr_en      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_vtx     = '{VTX_W'(i_vertex_d), VTX_W'(i_vertex_c),
                                  VTX_W'(i_vertex_b), VTX_W'(i_vertex_a)};
                    n_tnum    = r_tet_cnt;
                    n_tet_cnt = r_tet_cnt + 1'b1;
                    n_face    = '0;
                    n_addr    = '0;
                    n_state   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!hit && (r_addr < r_face_cnt)) begin
                    // keep streaming table reads
                    rd_en      = 1'b1;
                    n_addr     = r_addr + 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_addr[ADDR_W-1:0];
                end else begin
                    n_valid   = 1'b1;
                    n_o_tnum  = r_tnum;
                    n_o_slot  = cur_slot;
                    n_o_new   = 1'b0;
                    n_o_ntet  = '0;
                    n_o_nslot = '0;
                    n_o_full  = 1'b0;
                    n_o_idx   = '0;
                    n_o_last  = (r_face == FACE_LAST);
                    if (hit) begin
                        n_o_idx   = FIDX_W'(r_rd_idx);
                        n_o_ntet  = rd_owner[OWNER_W-1:SLOT_W];
                        n_o_nslot = rd_owner[SLOT_W-1:0];
                    end else if (r_face_cnt < CNT_W'(MAX_FACES)) begin
                        // append at the end of the table
                        wr_en      = 1'b1;
                        n_o_idx    = FIDX_W'(r_face_cnt);
                        n_o_new    = 1'b1;
                        n_face_cnt = r_face_cnt + 1'b1;
                    end else begin
                        n_o_full = 1'b1;
                    end
                    n_addr = '0;
                    if (r_face == FACE_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_face = r_face + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tet_cnt  <= '0;
            r_face_cnt <= '0;
            r_rd_valid <= 1'b0;
            r_valid    <= 1'b0;
            r_face     <= '0;
            r_addr     <= '0;
        end else begin
            r_tet_cnt  <= n_tet_cnt;
            r_face_cnt <= n_face_cnt;
            r_rd_valid <= n_rd_valid;
            r_valid    <= n_valid;
            r_face     <= n_face;
            r_addr     <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx     <= n_vtx;
        r_tnum    <= n_tnum;
        r_rd_idx  <= n_rd_idx;
        r_o_tnum  <= n_o_tnum;
        r_o_slot  <= n_o_slot;
        r_o_idx   <= n_o_idx;
        r_o_new   <= n_o_new;
        r_o_ntet  <= n_o_ntet;
        r_o_nslot <= n_o_nslot;
        r_o_full  <= n_o_full;
        r_o_last  <= n_o_last;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_tet_number    = r_o_tnum;
    assign o_face_slot     = r_o_slot;
    assign o_face_index    = r_o_idx;
    assign o_is_new        = r_o_new;
    assign o_neighbor_tet  = r_o_ntet;
    assign o_neighbor_slot = r_o_nslot;
    assign o_table_full    = r_o_full;
    assign o_last          = r_o_last;

    `ASSERT_CLK(a_valid_from_search, i_clk, i_rst_n,
        o_valid |-> $past(r_state == ST_SEARCH))
    `ASSERT_CLK(a_last_ends_item, i_clk, i_rst_n,
        (o_valid && o_last) |-> (r_state == ST_IDLE))
    `ASSERT_CLK(a_start_sets_busy, i_clk, i_rst_n,
        (start && !busy) |=> (busy && !o_valid))
    `ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n,
        r_face_cnt <= CNT_W'(MAX_FACES))

endmodule
